/* design/gne_pkg.sv */
package gne_pkg;

   localparam int IDX_W = 8;
   localparam int IDX_ENTRIES = 1 << IDX_W;
   localparam int KIND_W = 3;

   typedef enum logic [1:0] {
      REQ_SET  = 2'd0,
      REQ_READ = 2'd1,
      REQ_ADD  = 2'd2,
      REQ_SIM  = 2'd3
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_AND     = 3'd0,
      KIND_NAND    = 3'd1,
      KIND_OR      = 3'd2,
      KIND_NOR     = 3'd3,
      KIND_XOR     = 3'd4,
      KIND_XNOR    = 3'd5,
      KIND_NOT     = 3'd6,
      KIND_INVALID = 3'd7
   } gate_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_BAD_KIND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SIM,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sweep_status_type;

   function automatic logic gate_eval(gate_kind_type kind, logic a, logic b);
      logic y;
      case (kind)
         KIND_AND:  y = a & b;
         KIND_NAND: y = ~(a & b);
         KIND_OR:   y = a | b;
         KIND_NOR:  y = ~(a | b);
         KIND_XOR:  y = a ^ b;
         KIND_XNOR: y = ~(a ^ b);
         default:   y = ~a;
      endcase
      return y;
   endfunction

endpackage

/* design/gne_ram.sv */
module gne_ram import gne_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/gne_sweep.sv */
module gne_sweep import gne_pkg::*; #(
   parameter int NODE_W = 8,
   parameter int GATE_AW = 8,
   parameter int COUNT_W = 9,
   parameter int ENTRY_W = KIND_W + 3 * NODE_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [COUNT_W-1:0]     gate_count,
   output logic [GATE_AW-1:0]     gate_raddr,
   input  logic [ENTRY_W-1:0]     gate_rdata,
   output logic [NODE_W-1:0]      node_raddr_a,
   output logic [NODE_W-1:0]      node_raddr_b,
   input  logic                   node_qa,
   input  logic                   node_qb,
   output logic                   node_we,
   output logic [NODE_W-1:0]      node_waddr,
   output logic                   node_wdata,
   output sweep_status_type       status
);

   logic                running_ff, running_in;
   logic [COUNT_W-1:0]  gidx_ff, gidx_in;
   logic                g_vld_ff, g_vld_in;
   logic                n_vld_ff;
   gate_kind_type       n_kind_ff;
   logic [NODE_W-1:0]   n_out_ff;
   logic                fwd_a_ff, fwd_b_ff, fwd_val_ff;
   logic                issue;
   gate_kind_type       g_kind;
   logic [NODE_W-1:0]   g_in1, g_in2, g_out;
   logic                op_a, op_b;

   assign g_kind = gate_kind_type'(gate_rdata[ENTRY_W-1 -: KIND_W]);
   assign g_in1  = gate_rdata[3*NODE_W-1 -: NODE_W];
   assign g_in2  = gate_rdata[2*NODE_W-1 -: NODE_W];
   assign g_out  = gate_rdata[NODE_W-1:0];

   assign issue      = running_ff && (gidx_ff < gate_count);
   assign gate_raddr = gidx_ff[GATE_AW-1:0];

   assign node_raddr_a = g_in1;
   assign node_raddr_b = g_in2;

   assign op_a       = fwd_a_ff ? fwd_val_ff : node_qa;
   assign op_b       = fwd_b_ff ? fwd_val_ff : node_qb;
   assign node_we    = n_vld_ff;
   assign node_waddr = n_out_ff;
   assign node_wdata = gate_eval(n_kind_ff, op_a, op_b);

   assign status.busy = running_ff;
   assign status.done = running_ff && !issue && !g_vld_ff && !n_vld_ff;

   always_comb begin
      running_in = running_ff;
      gidx_in    = gidx_ff;
      g_vld_in   = 1'b0;
      if (start) begin
         running_in = 1'b1;
         gidx_in    = '0;
      end else if (issue) begin
         gidx_in  = gidx_ff + COUNT_W'(1);
         g_vld_in = 1'b1;
      end else if (status.done) begin
         running_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         g_vld_ff   <= 1'b0;
         n_vld_ff   <= 1'b0;
      end else begin
         running_ff <= running_in;
         g_vld_ff   <= g_vld_in;
         n_vld_ff   <= g_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      gidx_ff    <= gidx_in;
      n_kind_ff  <= g_kind;
      n_out_ff   <= g_out;
      fwd_a_ff   <= node_we && (g_in1 == node_waddr);
      fwd_b_ff   <= node_we && (g_in2 == node_waddr);
      fwd_val_ff <= node_wdata;
   end

endmodule

/* design/gate_netlist_evaluator_core.sv */
// Gate netlist evaluator with a store of one-bit nodes and a table of gates.
// Requests arrive as words on the req_ channel (req_valid, req_stall); each one
// produces exactly one result word on the rsp_ channel (rsp_valid, rsp_stall).
// A request is one of set node, read node, add gate or simulate.
// Set and add go from acceptance to the reply state; read passes a read state first.
// Simulate walks the gate table in creation order, one gate per cycle: each
// cycle reads one gate entry, reads both operand nodes and writes one node,
// with the last write forwarded to the next gate's operands. A simulate ends
// when the sweep has written the last node and reports done; with an empty
// table the sweep reports done as soon as the simulate state is entered.
// One request is processed at a time; the next one is accepted as soon as the
// current result sits in the output register, even if the receiver stalls, so
// with a ready receiver requests follow at the same spacing as their latency.
// A stalled result holds in the output register until it is taken.
// After reset the node store is cleared, one node per cycle, through all NODE_COUNT
// nodes; req_stall stays high during that pass. The gate count resets to zero.
module gate_netlist_evaluator_core import gne_pkg::*; #(
   parameter int NODE_COUNT = 256,
   parameter int GATE_COUNT = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_type,
   input  logic [7:0]   req_node_index,
   input  logic         req_node_value,
   input  logic [2:0]   req_gate_kind,
   input  logic [7:0]   req_first_input_index,
   input  logic [7:0]   req_second_input_index,
   input  logic [7:0]   req_output_index,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_read_value,
   output logic [1:0]   rsp_status
);

   localparam int NW = $clog2(NODE_COUNT);
   localparam int GW = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;
   localparam int CW = $clog2(GATE_COUNT + 1);
   localparam int EW = KIND_W + 3 * NW;

   state_type          state_ff, state_in;
   logic [NW-1:0]      clr_idx_ff, clr_idx_in;
   logic [CW-1:0]      gate_count_ff, gate_count_in;
   logic               res_value_ff, res_value_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_value_ff;
   status_type         rsp_status_ff;
   logic               load_out;

   logic [NW-1:0]      wrap_lut [IDX_ENTRIES];
   logic [NW-1:0]      w_node, w_in1, w_in2, w_out;
   logic               accept;
   req_kind_type       req_kind;
   gate_kind_type      kind;
   logic               table_full;
   logic               sweep_start;
   sweep_status_type   sweep_status;

   logic               gate_we;
   logic [EW-1:0]      gate_wdata, gate_rdata;
   logic [GW-1:0]      gate_raddr;

   logic               node_we;
   logic [NW-1:0]      node_waddr;
   logic               node_wdata;
   logic [NW-1:0]      node_raddr_a, node_raddr_b;
   logic               node_qa, node_qb;
   logic [NW-1:0]      sw_raddr_a, sw_raddr_b, sw_waddr;
   logic               sw_we, sw_wdata;

   for (genvar g = 0; g < IDX_ENTRIES; g++) begin : g_wrap
      assign wrap_lut[g] = NW'(g % NODE_COUNT);
   end

   assign w_node = wrap_lut[req_node_index];
   assign w_in1  = wrap_lut[req_first_input_index];
   assign w_in2  = wrap_lut[req_second_input_index];
   assign w_out  = wrap_lut[req_output_index];

   assign req_kind   = req_kind_type'(req_type);
   assign kind       = gate_kind_type'(req_gate_kind);
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign table_full = (gate_count_ff == CW'(GATE_COUNT));

   assign sweep_start = accept && (req_kind == REQ_SIM);
   assign gate_we     = accept && (req_kind == REQ_ADD) && (kind != KIND_INVALID) && !table_full;
   assign gate_wdata  = {kind, w_in1, w_in2, w_out};

   assign node_raddr_a = (state_ff == ST_SIM) ? sw_raddr_a : w_node;
   assign node_raddr_b = sw_raddr_b;

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         node_we    = 1'b1;
         node_waddr = clr_idx_ff;
         node_wdata = 1'b0;
      end else if (state_ff == ST_SIM) begin
         node_we    = sw_we;
         node_waddr = sw_waddr;
         node_wdata = sw_wdata;
      end else begin
         node_we    = accept && (req_kind == REQ_SET);
         node_waddr = w_node;
         node_wdata = req_node_value;
      end
   end

   gne_ram #(.WIDTH(EW), .DEPTH(GATE_COUNT), .AW(GW)) u_gate_ram (
      .clock (clock),
      .we    (gate_we),
      .waddr (gate_count_ff[GW-1:0]),
      .wdata (gate_wdata),
      .raddr (gate_raddr),
      .rdata (gate_rdata)
   );

   gne_ram #(.WIDTH(1), .DEPTH(NODE_COUNT), .AW(NW)) u_node_ram_a (
      .clock (clock),
      .we    (node_we),
      .waddr (node_waddr),
      .wdata (node_wdata),
      .raddr (node_raddr_a),
      .rdata (node_qa)
   );

   gne_ram #(.WIDTH(1), .DEPTH(NODE_COUNT), .AW(NW)) u_node_ram_b (
      .clock (clock),
      .we    (node_we),
      .waddr (node_waddr),
      .wdata (node_wdata),
      .raddr (node_raddr_b),
      .rdata (node_qb)
   );

   gne_sweep #(.NODE_W(NW), .GATE_AW(GW), .COUNT_W(CW), .ENTRY_W(EW)) u_sweep (
      .clock        (clock),
      .reset        (reset),
      .start        (sweep_start),
      .gate_count   (gate_count_ff),
      .gate_raddr   (gate_raddr),
      .gate_rdata   (gate_rdata),
      .node_raddr_a (sw_raddr_a),
      .node_raddr_b (sw_raddr_b),
      .node_qa      (node_qa),
      .node_qb      (node_qb),
      .node_we      (sw_we),
      .node_waddr   (sw_waddr),
      .node_wdata   (sw_wdata),
      .status       (sweep_status)
   );

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      gate_count_in = gate_count_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      load_out      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + NW'(1);
            if (clr_idx_ff == NW'(NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               res_value_in  = 1'b0;
               res_status_in = STATUS_OK;
               case (req_kind)
                  REQ_SET: begin
                     state_in = ST_REPLY;
                  end
                  REQ_READ: begin
                     state_in = ST_READ;
                  end
                  REQ_ADD: begin
                     state_in = ST_REPLY;
                     if (kind == KIND_INVALID) begin
                        res_status_in = STATUS_BAD_KIND;
                     end else if (table_full) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        gate_count_in = gate_count_ff + CW'(1);
                     end
                  end
                  default: begin
                     state_in = ST_SIM;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_value_in = node_qa;
            state_in     = ST_REPLY;
         end
         ST_SIM: begin
            if (sweep_status.done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         gate_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         gate_count_ff <= gate_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      if (load_out) begin
         rsp_value_ff  <= res_value_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

   a_rsp_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_REPLY))
      else $error("result word appeared outside the reply state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      gate_count_ff <= CW'(GATE_COUNT))
      else $error("gate count exceeds table depth");

   a_sweep_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !sweep_status.busy)
      else $error("simulation sweep running while idle");

   a_done_in_sim: assert property (@(posedge clock) disable iff (reset)
      sweep_status.done |-> (state_ff == ST_SIM))
      else $error("sweep finished outside the simulate state");

endmodule
